### src/hrft_pkg.sv
package hrft_pkg;

  // Parse phase, one-hot
  typedef enum logic [4:0] {
    PH_NAME = 5'b00001,
    PH_SKIP = 5'b00010,
    PH_LEN  = 5'b00100,
    PH_BODY = 5'b01000,
    PH_DONE = 5'b10000
  } phase_t;

  // Framing kinds
  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_CHUNKED = 2'd1;
  localparam logic [1:0] KIND_CLEN    = 2'd2;

  // Result events
  localparam logic [1:0] EV_HEADERS   = 2'd0;
  localparam logic [1:0] EV_COMPLETE  = 2'd1;
  localparam logic [1:0] EV_TRUNCATED = 2'd2;

  // Characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic [7:0] LEN_NAME_LEN = 8'd14;
  localparam logic [7:0] ENC_NAME_LEN = 8'd17;
  localparam logic [7:0] NAME_POS_MAX = 8'd255;

  // 0 CR LF CR LF
  localparam logic [39:0] CHUNK_TAIL = 40'h300D0A0D0A;

  // Per-line header tracking
  typedef struct packed {
    phase_t     phase;
    logic [7:0] name_pos;
    logic       len_match;
    logic       enc_match;
    logic       has_content;
    logic [1:0] kind;
    logic       len_taken;
  } line_t;

  localparam line_t LINE_RST = '{
    phase:       PH_NAME,
    name_pos:    8'd0,
    len_match:   1'b1,
    enc_match:   1'b1,
    has_content: 1'b0,
    kind:        KIND_UNKNOWN,
    len_taken:   1'b0
  };

  typedef struct packed {
    logic [1:0]  event_res;
    logic [1:0]  framing_type;
    logic [31:0] body_length;
    logic [15:0] header_length;
    logic        last_of_run;
  } result_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    to_lower = (c >= 8'h41 && c <= 8'h5A) ? (c + 8'd32) : c;
  endfunction

  // "content-length"
  function automatic logic [7:0] len_name_char(input logic [3:0] idx);
    case (idx)
      4'd0:    len_name_char = 8'h63;
      4'd1:    len_name_char = 8'h6F;
      4'd2:    len_name_char = 8'h6E;
      4'd3:    len_name_char = 8'h74;
      4'd4:    len_name_char = 8'h65;
      4'd5:    len_name_char = 8'h6E;
      4'd6:    len_name_char = 8'h74;
      4'd7:    len_name_char = 8'h2D;
      4'd8:    len_name_char = 8'h6C;
      4'd9:    len_name_char = 8'h65;
      4'd10:   len_name_char = 8'h6E;
      4'd11:   len_name_char = 8'h67;
      4'd12:   len_name_char = 8'h74;
      4'd13:   len_name_char = 8'h68;
      default: len_name_char = 8'h00;
    endcase
  endfunction

  // "transfer-encoding"
  function automatic logic [7:0] enc_name_char(input logic [4:0] idx);
    case (idx)
      5'd0:    enc_name_char = 8'h74;
      5'd1:    enc_name_char = 8'h72;
      5'd2:    enc_name_char = 8'h61;
      5'd3:    enc_name_char = 8'h6E;
      5'd4:    enc_name_char = 8'h73;
      5'd5:    enc_name_char = 8'h66;
      5'd6:    enc_name_char = 8'h65;
      5'd7:    enc_name_char = 8'h72;
      5'd8:    enc_name_char = 8'h2D;
      5'd9:    enc_name_char = 8'h65;
      5'd10:   enc_name_char = 8'h6E;
      5'd11:   enc_name_char = 8'h63;
      5'd12:   enc_name_char = 8'h6F;
      5'd13:   enc_name_char = 8'h64;
      5'd14:   enc_name_char = 8'h69;
      5'd15:   enc_name_char = 8'h6E;
      5'd16:   enc_name_char = 8'h67;
      default: enc_name_char = 8'h00;
    endcase
  endfunction

endpackage

### src/hrft_content_step.sv
module hrft_content_step #(
  parameter int LENGTH_BITS = 32
) (
  input  logic [7:0]             ch,
  input  hrft_pkg::line_t        st_i,
  input  logic [LENGTH_BITS-1:0] len_i,
  output hrft_pkg::line_t        st_o,
  output logic [LENGTH_BITS-1:0] len_o
);
  import hrft_pkg::*;

  logic [7:0]             lc;
  logic [3:0]             digit;
  logic [LENGTH_BITS+3:0] len_wide;
  logic [LENGTH_BITS+3:0] prod;
  logic                   prod_ovf;
  logic                   is_digit;
  logic [7:0]             pos_inc;

  assign lc       = to_lower(ch);
  assign digit    = ch[3:0];
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign pos_inc  = (st_i.name_pos == NAME_POS_MAX) ? st_i.name_pos : st_i.name_pos + 8'd1;

  // Accumulate one decimal digit, saturating
  assign len_wide = {4'b0000, len_i};
  assign prod     = (len_wide << 3) + (len_wide << 1) + {{LENGTH_BITS{1'b0}}, digit};
  assign prod_ovf = |prod[LENGTH_BITS+3:LENGTH_BITS];

  // Apply one content byte to the line tracking
  always_comb begin
    st_o             = st_i;
    len_o            = len_i;
    st_o.has_content = 1'b1;
    case (st_i.phase)
      PH_NAME: begin
        if (ch == CH_COLON) begin
          if (st_i.enc_match && st_i.name_pos == ENC_NAME_LEN) begin
            st_o.kind  = KIND_CHUNKED;
            st_o.phase = PH_SKIP;
          end else if (st_i.len_match && st_i.name_pos == LEN_NAME_LEN) begin
            if (st_i.kind != KIND_CHUNKED) st_o.kind = KIND_CLEN;
            st_o.phase = PH_LEN;
          end else begin
            st_o.phase = PH_SKIP;
          end
          st_o.name_pos = 8'd0;
        end else begin
          if (st_i.name_pos >= LEN_NAME_LEN || len_name_char(st_i.name_pos[3:0]) != lc)
            st_o.len_match = 1'b0;
          if (st_i.name_pos >= ENC_NAME_LEN || enc_name_char(st_i.name_pos[4:0]) != lc)
            st_o.enc_match = 1'b0;
          st_o.name_pos = pos_inc;
        end
      end
      PH_LEN: begin
        if (is_digit) begin
          if (!st_i.len_taken)
            len_o = prod_ovf ? '1 : prod[LENGTH_BITS-1:0];
          st_o.name_pos = pos_inc;
        end else if (!((ch == CH_SP || ch == CH_TAB) && st_i.name_pos == 8'd0)) begin
          // End of the value: lock it if any digit arrived
          if (st_i.name_pos != 8'd0) st_o.len_taken = 1'b1;
          st_o.phase = PH_SKIP;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### src/http_response_framing_tracker.sv
// Channel  Ports                                              Direction
// in       in_valid/in_ready, in_data_byte, in_new_response,  upstream bytes
//          in_end_of_data
// out      out_valid/out_ready, out_event_res,                framing results
//          out_framing_type, out_body_length,
//          out_header_length, out_last_of_run
//
// One byte is taken per cycle while in_ready is high; its results are written
// to a four-entry result queue at the end of that same cycle, then appear on
// out_. A byte yields zero, one or two results; in_ready is high while the queue
// has at least two free entries, so its depth sets how far out_ready may stall.
// rst_n is synchronous, active low, and clears all tracking and the queue.
module http_response_framing_tracker #(
  parameter int LENGTH_BITS       = 32,
  parameter int HEADER_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_new_response,
  input  logic        in_end_of_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_res,
  output logic [1:0]  out_framing_type,
  output logic [31:0] out_body_length,
  output logic [15:0] out_header_length,
  output logic        out_last_of_run
);
  import hrft_pkg::*;

  localparam int LW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;
  localparam int HW = (HEADER_COUNT_BITS > 16) ? HEADER_COUNT_BITS : 16;

  // Tracking state
  line_t                        line_r, line_nxt, cur_line;
  logic                         cr_r, cr_nxt, cur_cr;
  logic [LENGTH_BITS-1:0]       len_r, len_nxt, cur_len;
  logic [HEADER_COUNT_BITS-1:0] hdr_r, hdr_nxt, cur_hdr, hdr_inc;
  logic [LENGTH_BITS-1:0]       body_r, body_nxt, cur_body, body_inc;
  logic [39:0]                  tail_r, tail_nxt, cur_tail;

  line_t                  a_st, b_st;
  logic [LENGTH_BITS-1:0] a_len, b_len;

  logic       in_fire;
  logic [1:0] n_res;
  logic [1:0] ev0, ev1;
  logic       complete;

  // Result queue
  result_t    res_mem [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r;
  logic       out_fire;
  logic [1:0] push_n;
  result_t    res0, res1;

  logic [LW-1:0]   len_ext;
  logic [31:0]     bl_sat;
  logic [HW-1:0]   hdr_ext;
  logic [15:0]     hl_sat;

  assign in_ready = (cnt_r <= 3'd2);
  assign in_fire  = in_valid && in_ready;
  assign out_valid = (cnt_r != 3'd0);
  assign out_fire  = out_valid && out_ready;

  // Start from cleared state on a new response
  assign cur_line = in_new_response ? LINE_RST : line_r;
  assign cur_cr   = in_new_response ? 1'b0 : cr_r;
  assign cur_len  = in_new_response ? '0 : len_r;
  assign cur_hdr  = in_new_response ? '0 : hdr_r;
  assign cur_body = in_new_response ? '0 : body_r;
  assign cur_tail = in_new_response ? '0 : tail_r;

  assign hdr_inc  = (&cur_hdr) ? cur_hdr : cur_hdr + HEADER_COUNT_BITS'(1);
  assign body_inc = (&cur_body) ? cur_body : cur_body + LENGTH_BITS'(1);

  // First content byte: the held CR when one is pending, else this byte
  hrft_content_step #(.LENGTH_BITS(LENGTH_BITS)) u_step_a (
    .ch    (cur_cr ? CH_CR : in_data_byte),
    .st_i  (cur_line),
    .len_i (cur_len),
    .st_o  (a_st),
    .len_o (a_len)
  );

  // Second content byte: this byte after a held CR
  hrft_content_step #(.LENGTH_BITS(LENGTH_BITS)) u_step_b (
    .ch    (in_data_byte),
    .st_i  (a_st),
    .len_i (a_len),
    .st_o  (b_st),
    .len_o (b_len)
  );

  // Advance tracking for one byte
  always_comb begin
    line_nxt = cur_line;
    cr_nxt   = cur_cr;
    len_nxt  = cur_len;
    hdr_nxt  = cur_hdr;
    body_nxt = cur_body;
    tail_nxt = cur_tail;
    n_res    = 2'd0;
    ev0      = EV_HEADERS;
    ev1      = EV_COMPLETE;
    complete = 1'b0;
    case (cur_line.phase)
      PH_NAME, PH_SKIP, PH_LEN: begin
        hdr_nxt = hdr_inc;
        if (cur_cr && in_data_byte == CH_LF) begin
          cr_nxt = 1'b0;
          if (!cur_line.has_content) begin
            // Empty line: headers are done
            line_nxt.phase = PH_BODY;
            body_nxt = '0;
            tail_nxt = '0;
            n_res    = 2'd1;
            ev0      = EV_HEADERS;
            if (cur_line.kind == KIND_CLEN && cur_len == '0) begin
              n_res          = 2'd2;
              ev1            = EV_COMPLETE;
              line_nxt.phase = PH_DONE;
            end else if (in_end_of_data) begin
              n_res          = 2'd2;
              ev1            = (cur_line.kind == KIND_UNKNOWN) ? EV_COMPLETE : EV_TRUNCATED;
              line_nxt.phase = PH_DONE;
            end
          end else begin
            // Line end: close any length value, start a new line
            if (cur_line.phase == PH_LEN && cur_line.name_pos != 8'd0)
              line_nxt.len_taken = 1'b1;
            line_nxt.name_pos    = 8'd0;
            line_nxt.len_match   = 1'b1;
            line_nxt.enc_match   = 1'b1;
            line_nxt.has_content = 1'b0;
            line_nxt.phase       = PH_NAME;
          end
        end else if (cur_cr) begin
          line_nxt = a_st;
          len_nxt  = a_len;
          if (in_data_byte != CH_CR) begin
            cr_nxt   = 1'b0;
            line_nxt = b_st;
            len_nxt  = b_len;
          end
        end else if (in_data_byte == CH_CR) begin
          cr_nxt = 1'b1;
        end else begin
          line_nxt = a_st;
          len_nxt  = a_len;
        end
        if (n_res == 2'd0 && in_end_of_data) begin
          n_res          = 2'd1;
          ev0            = EV_TRUNCATED;
          line_nxt.phase = PH_DONE;
        end
      end
      PH_BODY: begin
        body_nxt = body_inc;
        tail_nxt = {cur_tail[31:0], in_data_byte};
        case (cur_line.kind)
          KIND_CHUNKED: complete = ({cur_tail[31:0], in_data_byte} == CHUNK_TAIL);
          KIND_CLEN:    complete = (body_inc >= cur_len);
          default:      complete = in_end_of_data;
        endcase
        if (complete) begin
          n_res          = 2'd1;
          ev0            = EV_COMPLETE;
          line_nxt.phase = PH_DONE;
        end else if (in_end_of_data) begin
          n_res          = 2'd1;
          ev0            = EV_TRUNCATED;
          line_nxt.phase = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // Clamp reported lengths to the port widths
  assign len_ext = LW'(len_nxt);
  assign bl_sat  = (|(len_ext >> 32)) ? 32'hFFFF_FFFF : len_ext[31:0];
  assign hdr_ext = HW'(hdr_nxt);
  assign hl_sat  = (|(hdr_ext >> 16)) ? 16'hFFFF : hdr_ext[15:0];

  always_comb begin
    res0.event_res     = ev0;
    res0.framing_type  = line_nxt.kind;
    res0.body_length   = (line_nxt.kind == KIND_CLEN) ? bl_sat : 32'd0;
    res0.header_length = hl_sat;
    res0.last_of_run   = (n_res == 2'd1);
    res1               = res0;
    res1.event_res     = ev1;
    res1.last_of_run   = 1'b1;
  end

  assign push_n = in_fire ? n_res : 2'd0;

  // Hold tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= LINE_RST;
      cr_r   <= 1'b0;
      len_r  <= '0;
      hdr_r  <= '0;
      body_r <= '0;
      tail_r <= '0;
    end else if (in_fire) begin
      line_r <= line_nxt;
      cr_r   <= cr_nxt;
      len_r  <= len_nxt;
      hdr_r  <= hdr_nxt;
      body_r <= body_nxt;
      tail_r <= tail_nxt;
    end
  end

  // Queue results
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) res_mem[wr_ptr_r] <= res0;
    if (push_n == 2'd2) res_mem[wr_ptr_r + 2'd1] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_n;
      if (out_fire) rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_r + {1'b0, push_n} - {2'b00, out_fire};
    end
  end

  assign out_event_res     = res_mem[rd_ptr_r].event_res;
  assign out_framing_type  = res_mem[rd_ptr_r].framing_type;
  assign out_body_length   = res_mem[rd_ptr_r].body_length;
  assign out_header_length = res_mem[rd_ptr_r].header_length;
  assign out_last_of_run   = res_mem[rd_ptr_r].last_of_run;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("result queue overflow");

  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(line_r.phase))
    else $error("parse phase not one-hot");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_new_response && line_r.phase == PH_DONE) |-> n_res == 2'd0)
    else $error("result after end of response");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && n_res == 2'd2) |-> ev0 == EV_HEADERS)
    else $error("second result without headers event");

  a_eod_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_end_of_data && (in_new_response || line_r.phase != PH_DONE))
      |-> n_res != 2'd0)
    else $error("end of data gave no result");

endmodule
